// ----- src/fdr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fdr_pkg;

  // Field widths.
  localparam int unsigned IndexWidth = 16;
  localparam int unsigned CosWidth   = 16;
  localparam int unsigned AbsWidth   = 15;
  localparam int unsigned ReflWidth  = 17;
  localparam int unsigned RootWidth  = 17;

  // Fixed-point constants.
  localparam logic signed [CosWidth-1:0] CosPosOne = 16'sd16384;
  localparam logic signed [CosWidth-1:0] CosNegOne = -16'sd16384;
  localparam logic [28:0]                Q28One    = 29'h1000_0000;
  localparam logic [24:0]                RatioOne  = 25'h100_0000;
  localparam logic [ReflWidth-1:0]       ReflOne   = 17'h1_0000;

  // Register reset values.
  localparam logic [IndexWidth-1:0] OutsideReset = 16'd4096;
  localparam logic [IndexWidth-1:0] InsideReset  = 16'd6144;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_INDEX_OUTSIDE = 1'b0,
    CFG_INDEX_INSIDE  = 1'b1
  } cfg_index_e;

  // Geometry that travels along the pipeline with each request.
  typedef struct packed {
    logic                  tir;
    logic [IndexWidth-1:0] ei;
    logic [IndexWidth-1:0] et;
    logic [AbsWidth-1:0]   a;
  } geom_t;

  // Flags that travel with the first ratio divider.
  typedef struct packed {
    logic tir;
    logic zero_den;
  } ratio_side_t;

endpackage

`default_nettype wire

// ----- src/fdr_div_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fdr_div_pipe #(
  parameter int unsigned NumWidth  = 61,
  parameter int unsigned DenWidth  = 32,
  parameter int unsigned QuotWidth = 28,
  parameter int unsigned SideWidth = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [NumWidth-1:0]  num_i,
  input  logic [DenWidth-1:0]  den_i,
  input  logic [SideWidth-1:0] side_i,
  output logic                 valid_o,
  output logic [QuotWidth-1:0] quot_o,
  output logic [SideWidth-1:0] side_o
);

  logic                 valid_q [QuotWidth];
  logic [NumWidth-1:0]  rem_q   [QuotWidth];
  logic [DenWidth-1:0]  den_q   [QuotWidth];
  logic [QuotWidth-1:0] quot_q  [QuotWidth];
  logic [SideWidth-1:0] side_q  [QuotWidth];

  // One restoring step per stage, quotient bits from the top down.
  for (genvar k = 0; k < QuotWidth; k++) begin : g_stage
    localparam int unsigned Shift = QuotWidth - 1 - k;

    logic                 vld_in;
    logic [NumWidth-1:0]  rem_in;
    logic [NumWidth-1:0]  trial;
    logic [DenWidth-1:0]  den_in;
    logic [QuotWidth-1:0] quot_in;
    logic [SideWidth-1:0] side_in;
    logic                 take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = num_i;
      assign den_in  = den_i;
      assign quot_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quot_in = quot_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = NumWidth'(den_in) << Shift;
    assign take  = rem_in >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? (rem_in - trial) : rem_in;
        den_q[k]  <= den_in;
        quot_q[k] <= {quot_in[QuotWidth-2:0], take};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QuotWidth-1];
  assign quot_o  = quot_q[QuotWidth-1];
  assign side_o  = side_q[QuotWidth-1];

endmodule

`default_nettype wire

// ----- src/fdr_sqrt_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fdr_sqrt_pipe #(
  parameter int unsigned ValWidth  = 33,
  parameter int unsigned RootWidth = 17,
  parameter int unsigned SideWidth = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [ValWidth-1:0]  val_i,
  input  logic [SideWidth-1:0] side_i,
  output logic                 valid_o,
  output logic [RootWidth-1:0] root_o,
  output logic [SideWidth-1:0] side_o
);

  localparam int unsigned Steps    = (ValWidth + 1) / 2;
  localparam int unsigned ResWidth = ValWidth + 1;

  logic                 valid_q [Steps];
  logic [ValWidth-1:0]  val_q   [Steps];
  logic [ResWidth-1:0]  res_q   [Steps];
  logic [SideWidth-1:0] side_q  [Steps];

  // Digit-by-digit square root, one result bit per stage.
  for (genvar k = 0; k < Steps; k++) begin : g_stage
    localparam int unsigned Shift = 2 * (Steps - 1 - k);

    logic                 vld_in;
    logic [ValWidth-1:0]  val_in;
    logic [ResWidth-1:0]  res_in;
    logic [SideWidth-1:0] side_in;
    logic [ResWidth-1:0]  bit_w;
    logic [ResWidth-1:0]  trial;
    logic                 take;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign val_in  = val_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = valid_q[k-1];
      assign val_in  = val_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign bit_w = ResWidth'(1) << Shift;
    assign trial = res_in + bit_w;
    assign take  = ResWidth'(val_in) >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[k]  <= take ? ValWidth'(ResWidth'(val_in) - trial) : val_in;
        res_q[k]  <= take ? ((res_in >> 1) + bit_w) : (res_in >> 1);
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign root_o  = RootWidth'(res_q[Steps-1]);
  assign side_o  = side_q[Steps-1];

endmodule

`default_nettype wire

// ----- src/fresnel_dielectric_reflectance_unit.sv -----
// Requests pass through 79 register stages in all before a result appears on the outputs;
// a stall from the output holds every stage.
// Throughput: one request per cycle while the output is not stalled.
// Most of the depth comes from the 28-stage transmitted-sine divider, the 17-stage square root
// and the two 25-stage amplitude-ratio dividers running side by side.
// Reset clears all valid bits and loads the refractive indices with 1.0 and 1.5.
`timescale 1ns / 1ps
`default_nettype none

module fresnel_dielectric_reflectance_unit
  import fdr_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_index_i,
  input  logic [IndexWidth-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [CosWidth-1:0] cos_incident_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [ReflWidth-1:0]   reflectance_o,
  output logic                   total_internal_o
);

  logic en;

  // Configuration registers, always ready.
  logic [IndexWidth-1:0] outside_q, inside_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outside_q <= OutsideReset;
      inside_q  <= InsideReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_INDEX_OUTSIDE: outside_q <= cfg_data_i;
        CFG_INDEX_INSIDE:  inside_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline moves whenever the output register can take a result.
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage 1: clamp the cosine and pick the incident and transmitted indices.
  logic signed [CosWidth-1:0] cos_clamp;
  logic                       entering;
  logic                       s1_valid_q;
  geom_t                      s1_geom_q;

  always_comb begin
    if (cos_incident_i > CosPosOne) begin
      cos_clamp = CosPosOne;
    end else if (cos_incident_i < CosNegOne) begin
      cos_clamp = CosNegOne;
    end else begin
      cos_clamp = cos_incident_i;
    end
  end

  assign entering = !cos_clamp[CosWidth-1] && (cos_clamp != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_geom_q.tir <= 1'b0;
      s1_geom_q.ei  <= entering ? outside_q : inside_q;
      s1_geom_q.et  <= entering ? inside_q : outside_q;
      s1_geom_q.a   <= cos_clamp[CosWidth-1] ? AbsWidth'(-cos_clamp) : AbsWidth'(cos_clamp);
    end
  end

  // Stage 2: squared sine of the incident angle and the squared indices.
  logic [29:0] a_sq;
  logic        s2_valid_q;
  geom_t       s2_geom_q;
  logic [28:0] s2_sin2_q;
  logic [31:0] s2_ei2_q, s2_et2_q;

  assign a_sq = {15'b0, s1_geom_q.a} * {15'b0, s1_geom_q.a};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_geom_q <= s1_geom_q;
      s2_sin2_q <= Q28One - a_sq[28:0];
      s2_ei2_q  <= {16'b0, s1_geom_q.ei} * {16'b0, s1_geom_q.ei};
      s2_et2_q  <= {16'b0, s1_geom_q.et} * {16'b0, s1_geom_q.et};
    end
  end

  // Stage 3: scaled squared transmitted sine numerator.
  logic        s3_valid_q;
  geom_t       s3_geom_q;
  logic [60:0] s3_num_q;
  logic [31:0] s3_et2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_geom_q <= s2_geom_q;
      s3_num_q  <= {29'b0, s2_ei2_q} * {32'b0, s2_sin2_q};
      s3_et2_q  <= s2_et2_q;
    end
  end

  // Stage 4: total internal reflection test.
  logic        s4_valid_q;
  geom_t       s4_geom_q;
  logic [60:0] s4_num_q;
  logic [31:0] s4_et2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_geom_q.tir <= s3_num_q >= {1'b0, s3_et2_q, 28'b0};
      s4_geom_q.ei  <= s3_geom_q.ei;
      s4_geom_q.et  <= s3_geom_q.et;
      s4_geom_q.a   <= s3_geom_q.a;
      s4_num_q      <= s3_num_q;
      s4_et2_q      <= s3_et2_q;
    end
  end

  // Squared transmitted sine, Q28.
  logic        d1_valid;
  logic [27:0] d1_quot;
  geom_t       d1_geom;

  fdr_div_pipe #(
    .NumWidth (61),
    .DenWidth (32),
    .QuotWidth(28),
    .SideWidth($bits(geom_t))
  ) u_sine_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s4_valid_q),
    .num_i  (s4_num_q),
    .den_i  (s4_et2_q),
    .side_i (s4_geom_q),
    .valid_o(d1_valid),
    .quot_o (d1_quot),
    .side_o (d1_geom)
  );

  // Stage 5: squared transmitted cosine in Q32 for the root.
  logic [28:0] cos2_t;
  logic        s5_valid_q;
  geom_t       s5_geom_q;
  logic [32:0] s5_val_q;

  assign cos2_t = Q28One - {1'b0, d1_quot};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else if (en) begin
      s5_valid_q <= d1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_geom_q <= d1_geom;
      s5_val_q  <= {cos2_t, 4'b0};
    end
  end

  // Transmitted cosine, Q16.
  logic                 sq_valid;
  logic [RootWidth-1:0] sq_root;
  geom_t                sq_geom;

  fdr_sqrt_pipe #(
    .ValWidth (33),
    .RootWidth(RootWidth),
    .SideWidth($bits(geom_t))
  ) u_cos_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s5_valid_q),
    .val_i  (s5_val_q),
    .side_i (s5_geom_q),
    .valid_o(sq_valid),
    .root_o (sq_root),
    .side_o (sq_geom)
  );

  // Stage 6: the four index-cosine products.
  logic [16:0] ac;
  logic        s6_valid_q;
  logic        s6_tir_q;
  logic [32:0] s6_ta_q, s6_ic_q, s6_ia_q, s6_tc_q;

  assign ac = {sq_geom.a, 2'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else if (en) begin
      s6_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_tir_q <= sq_geom.tir;
      s6_ta_q  <= {17'b0, sq_geom.et} * {16'b0, ac};
      s6_ic_q  <= {17'b0, sq_geom.ei} * {16'b0, sq_root};
      s6_ia_q  <= {17'b0, sq_geom.ei} * {16'b0, ac};
      s6_tc_q  <= {17'b0, sq_geom.et} * {16'b0, sq_root};
    end
  end

  // Stage 7: ratio numerators and denominators.
  logic [33:0] par_den, perp_den;
  logic [32:0] par_num, perp_num;
  logic        s7_valid_q;
  ratio_side_t s7_side_q;
  logic        s7_perp_zero_q;
  logic [57:0] s7_par_num_q, s7_perp_num_q;
  logic [33:0] s7_par_den_q, s7_perp_den_q;

  assign par_den  = {1'b0, s6_ta_q} + {1'b0, s6_ic_q};
  assign perp_den = {1'b0, s6_ia_q} + {1'b0, s6_tc_q};
  assign par_num  = (s6_ta_q >= s6_ic_q) ? (s6_ta_q - s6_ic_q) : (s6_ic_q - s6_ta_q);
  assign perp_num = (s6_ia_q >= s6_tc_q) ? (s6_ia_q - s6_tc_q) : (s6_tc_q - s6_ia_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
    end else if (en) begin
      s7_valid_q <= s6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_side_q.tir      <= s6_tir_q;
      s7_side_q.zero_den <= par_den == '0;
      s7_perp_zero_q     <= perp_den == '0;
      s7_par_num_q       <= {1'b0, par_num, 24'b0};
      s7_perp_num_q      <= {1'b0, perp_num, 24'b0};
      s7_par_den_q       <= par_den;
      s7_perp_den_q      <= perp_den;
    end
  end

  // Parallel and perpendicular amplitude ratios, Q24.
  logic        par_valid, perp_valid;
  logic [24:0] par_quot, perp_quot;
  ratio_side_t par_side;
  logic        perp_zero;

  fdr_div_pipe #(
    .NumWidth (58),
    .DenWidth (34),
    .QuotWidth(25),
    .SideWidth($bits(ratio_side_t))
  ) u_par_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s7_valid_q),
    .num_i  (s7_par_num_q),
    .den_i  (s7_par_den_q),
    .side_i (s7_side_q),
    .valid_o(par_valid),
    .quot_o (par_quot),
    .side_o (par_side)
  );

  fdr_div_pipe #(
    .NumWidth (58),
    .DenWidth (34),
    .QuotWidth(25),
    .SideWidth(1)
  ) u_perp_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s7_valid_q),
    .num_i  (s7_perp_num_q),
    .den_i  (s7_perp_den_q),
    .side_i (s7_perp_zero_q),
    .valid_o(perp_valid),
    .quot_o (perp_quot),
    .side_o (perp_zero)
  );

  // Stage 8: square the ratios; a zero denominator counts as a ratio of one.
  logic [24:0] par_r, perp_r;
  logic        s8_valid_q;
  logic        s8_tir_q;
  logic [49:0] s8_par_sq_q, s8_perp_sq_q;

  assign par_r  = par_side.zero_den ? RatioOne : par_quot;
  assign perp_r = perp_zero ? RatioOne : perp_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_valid_q <= 1'b0;
    end else if (en) begin
      s8_valid_q <= par_valid && perp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_tir_q     <= par_side.tir;
      s8_par_sq_q  <= {25'b0, par_r} * {25'b0, par_r};
      s8_perp_sq_q <= {25'b0, perp_r} * {25'b0, perp_r};
    end
  end

  // Output stage: average with round half up, saturate, apply total reflection.
  logic [50:0] sq_sum;
  logic [17:0] refl_wide;
  logic [ReflWidth-1:0] refl_sat;
  logic [ReflWidth-1:0] refl_q;
  logic                 tir_q;

  assign sq_sum    = {1'b0, s8_par_sq_q} + {1'b0, s8_perp_sq_q} + (51'd1 << 32);
  assign refl_wide = sq_sum[50:33];
  assign refl_sat  = (refl_wide > {1'b0, ReflOne}) ? ReflOne : refl_wide[ReflWidth-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s8_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      refl_q <= s8_tir_q ? ReflOne : refl_sat;
      tir_q  <= s8_tir_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign reflectance_o    = refl_q;
  assign total_internal_o = tir_q;

  // Checks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && total_internal_o |-> reflectance_o == ReflOne)
    else $error("total internal reflection without full reflectance");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> reflectance_o <= ReflOne)
    else $error("reflectance above one");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    par_valid |-> perp_valid)
    else $error("ratio dividers out of step");

endmodule

`default_nettype wire

// ----- bench/tb_fresnel_dielectric_reflectance_unit.sv -----
`timescale 1ns / 1ps

module tb_fresnel_dielectric_reflectance_unit
  import fdr_pkg::*;
;

  localparam int PipeLatency = 79;
  localparam int WatchdogLimit = 20000;
  localparam int LongStall = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [IndexWidth-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CosWidth-1:0] cos_incident_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ReflWidth-1:0] reflectance_o;
  logic total_internal_o;

  typedef struct {
    logic [ReflWidth-1:0] refl;
    logic tir;
  } fresnel_result_t;

  // Predictor copy of the two index registers.
  logic [IndexWidth-1:0] n_outside = OutsideReset;
  logic [IndexWidth-1:0] n_inside = InsideReset;

  fresnel_result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  int tir_seen = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  bit stall_request = 1'b0;
  bit stall_done = 1'b0;
  int hold_off = 0;
  int quiet_cycles = 0;

  fresnel_dielectric_reflectance_unit uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Integer square root by bitwise search.
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((root | (64'd1 << b)) * (root | (64'd1 << b)) <= v) root |= 64'd1 << b;
    end
    return root;
  endfunction

  function automatic longint unsigned amplitude_ratio(longint unsigned x, longint unsigned y);
    longint unsigned num;
    num = (x >= y) ? x - y : y - x;
    if (x + y == 0) return 64'd1 << 24;
    return (num << 24) / (x + y);
  endfunction

  // Expected reflectance for one cosine under the current indices.
  function automatic fresnel_result_t fresnel_reflectance(logic signed [CosWidth-1:0] cosv);
    fresnel_result_t res;
    int c;
    longint unsigned a, s2, ei, et, q, ct, ac, r1, r2, refl;
    c = cosv;
    if (c > 16384) c = 16384;
    if (c < -16384) c = -16384;
    a = (c < 0) ? -c : c;
    ei = (c > 0) ? n_outside : n_inside;
    et = (c > 0) ? n_inside : n_outside;
    s2 = (64'd1 << 28) - a * a;
    if (ei * ei * s2 >= et * et * (64'd1 << 28)) begin
      res.refl = 17'h1_0000;
      res.tir = 1'b1;
      return res;
    end
    q = (ei * ei * s2) / (et * et);
    ct = int_sqrt(((64'd1 << 28) - q) << 4);
    ac = a << 2;
    r1 = amplitude_ratio(et * ac, ei * ct);
    r2 = amplitude_ratio(ei * ac, et * ct);
    refl = (r1 * r1 + r2 * r2 + (64'd1 << 32)) >> 33;
    if (refl > 65536) refl = 65536;
    res.refl = refl[ReflWidth-1:0];
    res.tir = 1'b0;
    return res;
  endfunction

  // Result checker and receiver stall control.
  always @(posedge clk_i) begin
    fresnel_result_t exp_r;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result refl=%0d tir=%0b", $time, reflectance_o,
                 total_internal_o);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.tir) tir_seen++;
        if (reflectance_o !== exp_r.refl) begin
          $display("%0t: reflectance expected %0d actual %0d", $time, exp_r.refl,
                   reflectance_o);
          errors++;
        end
        if (total_internal_o !== exp_r.tir) begin
          $display("%0t: total_internal expected %0b actual %0b", $time, exp_r.tir,
                   total_internal_o);
          errors++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (stall_request && !stall_done) begin
      hold_off <= LongStall;
      stall_done <= 1'b1;
      out_ready_i <= 1'b0;
    end else if (receiver_idles && $urandom_range(0, 9) == 0) begin
      hold_off <= $urandom_range(1, 14);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles with no accepted request or result.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog expired with %0d results pending.", pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one cosine request, with an optional random gap first.
  task automatic send_cosine(logic signed [CosWidth-1:0] cosv);
    if (sender_idles && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cos_incident_i <= cosv;
    pending_results.push_back(fresnel_reflectance(cosv));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 5) @(posedge clk_i);
  endtask

  task automatic write_index(cfg_index_e idx, logic [IndexWidth-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_INDEX_OUTSIDE) n_outside = value;
    else n_inside = value;
  endtask

  function automatic logic signed [CosWidth-1:0] random_cosine();
    case ($urandom_range(0, 9))
      0: return CosWidth'($urandom);
      1: return CosWidth'($urandom_range(0, 40) - 20);
      2: return CosWidth'(16384 - $urandom_range(0, 40));
      default: return CosWidth'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // Extremes of the cosine, both signs, zero and out-of-range values.
  task automatic test_directed;
    logic signed [CosWidth-1:0] corner[20] = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd1,
        -16'sd1, 16'sd16383, -16'sd16383, 16'sd8192, -16'sd8192, 16'sh7fff, 16'sh8000,
        16'sd16385, -16'sd16385, 16'sd11585, -16'sd11585, 16'sd100, -16'sd100,
        16'sh5555, 16'shaaaa, 16'sd2};
    foreach (corner[i]) send_cosine(corner[i]);
    drain();
  endtask

  // Index settings including extremes, with random cosines under each.
  task automatic test_index_settings;
    logic [IndexWidth-1:0] outs[6] = '{16'd1, 16'hffff, 16'd6144, 16'd4096, 16'd0, 16'd5461};
    logic [IndexWidth-1:0] ins[6] = '{16'hffff, 16'd1, 16'd4096, 16'd0, 16'd4096, 16'd9830};
    for (int s = 0; s < 6; s++) begin
      write_index(CFG_INDEX_OUTSIDE, outs[s]);
      write_index(CFG_INDEX_INSIDE, ins[s]);
      repeat (60) send_cosine(random_cosine());
      drain();
    end
  endtask

  // Random indices and cosines with random idling on both sides.
  task automatic test_random_stream;
    for (int p = 0; p < 10; p++) begin
      write_index(CFG_INDEX_OUTSIDE, IndexWidth'($urandom_range(1, 65535)));
      write_index(CFG_INDEX_INSIDE, ($urandom_range(0, 3) == 0) ?
                  IndexWidth'($urandom_range(1, 65535)) :
                  IndexWidth'($urandom_range(3000, 12000)));
      repeat (110) send_cosine(random_cosine());
      drain();
    end
  endtask

  // Long receiver stall while requests keep coming so the pipeline backs up.
  task automatic test_backpressure;
    sender_idles = 1'b0;
    stall_request = 1'b1;
    repeat (200) send_cosine(random_cosine());
    sender_idles = 1'b1;
    drain();
  endtask

  // Final stretch with no idling at all.
  task automatic test_full_rate;
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    write_index(CFG_INDEX_OUTSIDE, 16'd4096);
    write_index(CFG_INDEX_INSIDE, 16'd6144);
    repeat (200) send_cosine(random_cosine());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_index_settings();
    test_random_stream();
    test_backpressure();
    test_full_rate();
    $display("Covered %0d results (%0d total internal) over corner cosines, index",
             results_seen, tir_seen);
    $display("extremes, random settings, a long output stall and a full-rate stretch.");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
